// File: rtl/core/qxmm_pkg.sv
package qxmm_pkg;

  // width of a mixed, floored drive: holds a full 16 bit throttle plus three full terms
  localparam int unsigned MW = 18;
  localparam int unsigned NUM_MOTORS = 4;

  // product width: 18 bit signed command times 17 bit signed gain
  localparam int unsigned PW = 35;

  // motor order in the drive arrays
  localparam int unsigned MOT_FR = 0;
  localparam int unsigned MOT_FL = 1;
  localparam int unsigned MOT_RL = 2;
  localparam int unsigned MOT_RR = 3;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_ATTITUDE_GAIN = 2'd0,
    CFG_YAW_GAIN      = 2'd1,
    CFG_IDLE_FLOOR    = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] ATTITUDE_GAIN_RST = 16'd13107;
  localparam logic [15:0] YAW_GAIN_RST      = 16'd26214;
  localparam logic [15:0] IDLE_FLOOR_RST    = 16'd1638;
  localparam logic [15:0] DRIVE_MAX         = 16'hFFFF;

  typedef struct packed {
    logic        [15:0] throttle;
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_cmd;
  } in_t;

  typedef struct packed {
    logic [15:0] drive_front_right;
    logic [15:0] drive_front_left;
    logic [15:0] drive_rear_left;
    logic [15:0] drive_rear_right;
    logic        scaled_down;
  } out_t;

  typedef struct packed {
    logic [15:0] attitude_gain;
    logic [15:0] yaw_gain;
    logic [15:0] idle_floor;
  } cfg_t;

  // floored drives, their peak and the rescale decision
  typedef struct packed {
    logic [NUM_MOTORS-1:0][MW-1:0] drive;
    logic [MW-1:0]                 peak;
    logic                          scaled;
  } mix_t;

endpackage

// File: rtl/core/quad_x_motor_mixer.sv
// throughput: one transaction per cycle unless the output stalls; three mixer stages,
//   one restoring divider stage per quotient bit, one output register
// stalls propagate stage by stage, empty stages fill while the output waits
// reset: asynchronous active low, clears all valid bits and loads the gain and
//   idle floor registers with their defaults
module quad_x_motor_mixer import qxmm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  localparam int unsigned SW = ((FRAC_BITS + 1) > MW) ? (FRAC_BITS + 1) : MW;

  // configuration registers
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attitude_gain <= ATTITUDE_GAIN_RST;
      cfg_q.yaw_gain      <= YAW_GAIN_RST;
      cfg_q.idle_floor    <= IDLE_FLOOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ATTITUDE_GAIN: cfg_q.attitude_gain <= cfg_data_i;
        CFG_YAW_GAIN:      cfg_q.yaw_gain      <= cfg_data_i;
        CFG_IDLE_FLOOR:    cfg_q.idle_floor    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // mix, floor and peak
  logic mix_valid, mix_ready;
  mix_t mix_data;

  qxmm_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (mix_valid),
    .ready_i (mix_ready),
    .data_o  (mix_data)
  );

  // rescale by one over the peak
  logic div_valid, div_ready;
  mix_t div_data;
  logic [NUM_MOTORS-1:0][FRAC_BITS:0] div_quot;

  qxmm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .ready_o (mix_ready),
    .data_i  (mix_data),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .data_o  (div_data),
    .quot_o  (div_quot)
  );

  // output register: pick scaled or plain drive, saturate to 16 bits
  logic [NUM_MOTORS-1:0][15:0] drv_sat;
  logic out_valid_q;
  out_t out_q;

  always_comb begin
    logic [SW-1:0] sel;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      sel        = div_data.scaled ? SW'(div_quot[i]) : SW'(div_data.drive[i]);
      drv_sat[i] = (sel > SW'(DRIVE_MAX)) ? DRIVE_MAX : sel[15:0];
    end
  end

  assign div_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready && div_valid) begin
      out_q.drive_front_right <= drv_sat[MOT_FR];
      out_q.drive_front_left  <= drv_sat[MOT_FL];
      out_q.drive_rear_left   <= drv_sat[MOT_RL];
      out_q.drive_rear_right  <= drv_sat[MOT_RR];
      out_q.scaled_down       <= div_data.scaled;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/qxmm_mix.sv
module qxmm_mix import qxmm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  in_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output mix_t data_o
);

  localparam int unsigned CW = FRAC_BITS + MW + 1;
  localparam logic [CW-1:0] ONE_FX = CW'(1) << FRAC_BITS;

  // stage enables, bubbles collapse
  logic [2:0] v_q;
  logic en_a, en_b, en_c;

  assign en_c    = !v_q[2] || ready_i;
  assign en_b    = !v_q[1] || en_c;
  assign en_a    = !v_q[0] || en_b;
  assign ready_o = en_a;
  assign valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_a) v_q[0] <= valid_i;
      if (en_b) v_q[1] <= v_q[0];
      if (en_c) v_q[2] <= v_q[1];
    end
  end

  // stage a: gain products, roll negated
  logic signed [17:0] roll_neg, pitch_ext, yaw_ext;
  logic signed [16:0] att_s, yaw_s;
  logic signed [PW-1:0] prod_r_d, prod_p_d, prod_y_d;
  logic signed [PW-1:0] prod_r_q, prod_p_q, prod_y_q;
  logic [15:0] thr_q;

  assign roll_neg  = -{{2{data_i.roll_cmd[15]}}, data_i.roll_cmd};
  assign pitch_ext = {{2{data_i.pitch_cmd[15]}}, data_i.pitch_cmd};
  assign yaw_ext   = {{2{data_i.yaw_cmd[15]}}, data_i.yaw_cmd};
  assign att_s     = {1'b0, cfg_i.attitude_gain};
  assign yaw_s     = {1'b0, cfg_i.yaw_gain};
  assign prod_r_d  = roll_neg * att_s;
  assign prod_p_d  = pitch_ext * att_s;
  assign prod_y_d  = yaw_ext * yaw_s;

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      prod_r_q <= prod_r_d;
      prod_p_q <= prod_p_d;
      prod_y_q <= prod_y_d;
      thr_q    <= data_i.throttle;
    end
  end

  // stage b: floor of q16 terms, x-quad sign pattern, idle floor
  logic signed [20:0] r_t, p_t, y_t, t_t, fl_t;
  logic signed [20:0] raw [NUM_MOTORS];
  logic [NUM_MOTORS-1:0][MW-1:0] drv_d, drv_q;

  assign r_t  = 21'($signed(prod_r_q[PW-1:16]));
  assign p_t  = 21'($signed(prod_p_q[PW-1:16]));
  assign y_t  = 21'($signed(prod_y_q[PW-1:16]));
  assign t_t  = {5'b0, thr_q};
  assign fl_t = {5'b0, cfg_i.idle_floor};

  always_comb begin
    raw[MOT_FR] = t_t - r_t + p_t + y_t;
    raw[MOT_FL] = t_t + r_t + p_t - y_t;
    raw[MOT_RL] = t_t + r_t - p_t + y_t;
    raw[MOT_RR] = t_t - r_t - p_t - y_t;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      drv_d[i] = (raw[i] < fl_t) ? MW'(cfg_i.idle_floor) : raw[i][MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) drv_q <= drv_d;
  end

  // stage c: peak of the four drives and rescale decision
  logic [MW-1:0] pk_a, pk_b, pk;
  mix_t out_d, out_q;

  always_comb begin
    pk_a = (drv_q[MOT_FL] > drv_q[MOT_FR]) ? drv_q[MOT_FL] : drv_q[MOT_FR];
    pk_b = (drv_q[MOT_RR] > drv_q[MOT_RL]) ? drv_q[MOT_RR] : drv_q[MOT_RL];
    pk   = (pk_b > pk_a) ? pk_b : pk_a;
    out_d.drive  = drv_q;
    out_d.peak   = pk;
    out_d.scaled = CW'(pk) > ONE_FX;
  end

  always_ff @(posedge clk_i) begin
    if (en_c) out_q <= out_d;
  end

  assign data_o = out_q;

endmodule

// File: rtl/core/qxmm_div.sv
module qxmm_div import qxmm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  mix_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output mix_t data_o,
  output logic [NUM_MOTORS-1:0][FRAC_BITS:0] quot_o
);

  // one quotient bit per stage, four lanes side by side
  localparam int unsigned K  = FRAC_BITS + 1;
  localparam int unsigned QW = FRAC_BITS + 1;

  logic [K-1:0] v_q;
  logic [K:0]   en;
  mix_t                          pl_q   [K];
  logic [NUM_MOTORS-1:0][MW-1:0] rem_q  [K];
  logic [NUM_MOTORS-1:0][QW-1:0] quot_q [K];

  assign en[K]   = ready_i;
  assign ready_o = en[0];
  assign valid_o = v_q[K-1];
  assign data_o  = pl_q[K-1];
  assign quot_o  = quot_q[K-1];

  for (genvar j = 0; j < K; j++) begin : g_stage
    logic                          v_in;
    mix_t                          pl_in;
    logic [NUM_MOTORS-1:0][MW-1:0] rem_prev;
    logic [NUM_MOTORS-1:0][QW-1:0] quot_prev;
    logic [NUM_MOTORS-1:0][MW-1:0] rem_d;
    logic [NUM_MOTORS-1:0][QW-1:0] quot_d;

    assign en[j] = !v_q[j] || en[j+1];

    if (j == 0) begin : g_first
      assign v_in      = valid_i;
      assign pl_in     = data_i;
      assign rem_prev  = '0;
      assign quot_prev = '0;
    end else begin : g_next
      assign v_in      = v_q[j-1];
      assign pl_in     = pl_q[j-1];
      assign rem_prev  = rem_q[j-1];
      assign quot_prev = quot_q[j-1];
    end

    // restoring step: first stage starts from the drive, later ones double the remainder
    always_comb begin
      logic [MW:0] trial;
      logic        qbit;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        trial     = (j == 0) ? {1'b0, pl_in.drive[i]} : {rem_prev[i], 1'b0};
        qbit      = trial >= {1'b0, pl_in.peak};
        rem_d[i]  = qbit ? MW'(trial - {1'b0, pl_in.peak}) : trial[MW-1:0];
        quot_d[i] = {quot_prev[i][QW-2:0], qbit};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        pl_q[j]   <= pl_in;
        rem_q[j]  <= rem_d;
        quot_q[j] <= quot_d;
      end
    end
  end

endmodule

// File: rtl/core/qxmm_chk.sv
module qxmm_chk import qxmm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15
) (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  localparam int unsigned CW = FRAC_BITS + 2;
  localparam logic [CW-1:0] ONE_FX = CW'(1) << FRAC_BITS;
  localparam logic [15:0] PEAK_OUT = (ONE_FX > CW'(DRIVE_MAX)) ? DRIVE_MAX : ONE_FX[15:0];

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // after rescaling no drive exceeds 1.0
  a_scaled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scaled_down |->
      CW'(out_data_o.drive_front_right) <= ONE_FX &&
      CW'(out_data_o.drive_front_left)  <= ONE_FX &&
      CW'(out_data_o.drive_rear_left)   <= ONE_FX &&
      CW'(out_data_o.drive_rear_right)  <= ONE_FX)
    else $error("rescaled drive above full scale");

  // after rescaling the largest motor lands exactly on 1.0
  a_scaled_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scaled_down |->
      out_data_o.drive_front_right == PEAK_OUT ||
      out_data_o.drive_front_left  == PEAK_OUT ||
      out_data_o.drive_rear_left   == PEAK_OUT ||
      out_data_o.drive_rear_right  == PEAK_OUT)
    else $error("rescaled peak not at full scale");

endmodule

bind quad_x_motor_mixer qxmm_chk #(.FRAC_BITS(FRAC_BITS)) u_qxmm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: tb/qxmm_checker.sv
module qxmm_checker import qxmm_pkg::*; #(
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          rescale_count_o
);

  localparam int unsigned PRINT_CAP = 30;

  // drive sets predicted for accepted commands, oldest first
  out_t drive_sets_q[$];
  // shadow of the gain and floor registers
  cfg_t regs;

  // one mismatch: print a line (up to a cap) and count it
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  // mix one command set into four drives with floor and rescale
  function automatic out_t mix_drives(input in_t cmd, input cfg_t cfg);
    longint one_fx;
    longint thr;
    longint roll_t;
    longint pitch_t;
    longint yaw_t;
    longint peak;
    longint drv [NUM_MOTORS];
    logic   rescale;
    out_t   res;
    one_fx  = longint'(1) << FRAC_BITS;
    thr     = longint'(cmd.throttle);
    // weighted terms, floor division by 2^16 via arithmetic shift
    roll_t  = (-longint'($signed(cmd.roll_cmd)) * longint'(cfg.attitude_gain)) >>> 16;
    pitch_t = (longint'($signed(cmd.pitch_cmd)) * longint'(cfg.attitude_gain)) >>> 16;
    yaw_t   = (longint'($signed(cmd.yaw_cmd)) * longint'(cfg.yaw_gain)) >>> 16;
    // x-quad sign pattern
    drv[MOT_FR] = thr - roll_t + pitch_t + yaw_t;
    drv[MOT_FL] = thr + roll_t + pitch_t - yaw_t;
    drv[MOT_RL] = thr + roll_t - pitch_t + yaw_t;
    drv[MOT_RR] = thr - roll_t - pitch_t - yaw_t;
    // idle floor, then peak
    peak = 0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (drv[i] < longint'(cfg.idle_floor)) drv[i] = longint'(cfg.idle_floor);
      if (i == 0 || drv[i] > peak) peak = drv[i];
    end
    // scale everything down when the peak is above 1.0
    rescale = (peak > one_fx);
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (rescale) drv[i] = (drv[i] * one_fx) / peak;
      if (drv[i] < 0) drv[i] = 0;
      if (drv[i] > longint'(DRIVE_MAX)) drv[i] = longint'(DRIVE_MAX);
    end
    res.drive_front_right = drv[MOT_FR][15:0];
    res.drive_front_left  = drv[MOT_FL][15:0];
    res.drive_rear_left   = drv[MOT_RL][15:0];
    res.drive_rear_right  = drv[MOT_RR][15:0];
    res.scaled_down       = rescale;
    return res;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      regs.attitude_gain = ATTITUDE_GAIN_RST;
      regs.yaw_gain      = YAW_GAIN_RST;
      regs.idle_floor    = IDLE_FLOOR_RST;
      drive_sets_q.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      result_count_o  = 0;
      rescale_count_o = 0;
    end else begin
      // register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ATTITUDE_GAIN: regs.attitude_gain = cfg_data_i;
          CFG_YAW_GAIN:      regs.yaw_gain      = cfg_data_i;
          CFG_IDLE_FLOOR:    regs.idle_floor    = cfg_data_i;
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (drive_sets_q.size() == 0) begin
          report_mismatch("unexpected result", out_data_i.drive_front_right, '0);
        end else begin
          want = drive_sets_q.pop_front();
          if (out_data_i.drive_front_right !== want.drive_front_right)
            report_mismatch("drive_front_right", out_data_i.drive_front_right,
                            want.drive_front_right);
          if (out_data_i.drive_front_left !== want.drive_front_left)
            report_mismatch("drive_front_left", out_data_i.drive_front_left,
                            want.drive_front_left);
          if (out_data_i.drive_rear_left !== want.drive_rear_left)
            report_mismatch("drive_rear_left", out_data_i.drive_rear_left,
                            want.drive_rear_left);
          if (out_data_i.drive_rear_right !== want.drive_rear_right)
            report_mismatch("drive_rear_right", out_data_i.drive_rear_right,
                            want.drive_rear_right);
          if (out_data_i.scaled_down !== want.scaled_down)
            report_mismatch("scaled_down", 16'(out_data_i.scaled_down),
                            16'(want.scaled_down));
          result_count_o++;
          if (want.scaled_down) rescale_count_o++;
        end
      end
      // command transaction: predict its drive set
      if (in_valid_i && in_ready_i) begin
        drive_sets_q.push_back(mix_drives(in_data_i, regs));
      end
      pending_o = drive_sets_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import qxmm_pkg::*;

  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned LATENCY    = FRAC_BITS + 5;
  localparam int          NUM_PHASES = 8;
  localparam int          PHASE_CMDS = 100;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;

  int fail_count;
  int pending;
  int result_count;
  int rescale_count;
  int cmds_sent;
  int reg_writes;
  bit idle_on;
  bit stall_on;

  quad_x_motor_mixer #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  qxmm_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .rescale_count_o(rescale_count)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= !(stall_on && $urandom_range(99) < 24);
  end

  // hard stop
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one command transaction, with a random gap ahead of it
  task automatic send_command(input in_t cmd);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(99) < 24) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cmds_sent++;
  endtask

  task automatic send_fields(input logic [15:0] thr, input logic [15:0] roll,
                             input logic [15:0] pitch, input logic [15:0] yaw);
    in_t cmd;
    cmd.throttle  = thr;
    cmd.roll_cmd  = roll;
    cmd.pitch_cmd = pitch;
    cmd.yaw_cmd   = yaw;
    send_command(cmd);
  endtask

  // stop sending until every predicted drive set has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // one register write transaction
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  // attitude command: half near hover, the rest full range or extremes
  function automatic logic [15:0] random_axis();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return 16'($urandom());
      default: return 16'($urandom_range(8191)) - 16'd4096;
    endcase
  endfunction

  function automatic in_t random_command();
    in_t cmd;
    cmd.throttle  = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(32768));
    cmd.roll_cmd  = random_axis();
    cmd.pitch_cmd = random_axis();
    cmd.yaw_cmd   = random_axis();
    return cmd;
  endfunction

  // stimulus and verdict
  initial begin
    logic [15:0] ag;
    logic [15:0] yg;
    logic [15:0] fl;
    int          pause_at;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at the reset gains and floor
    send_fields(16'd0,     16'd0,     16'd0,     16'd0);
    send_fields(16'd32768, 16'd0,     16'd0,     16'd0);
    send_fields(16'd65535, 16'd0,     16'd0,     16'd0);
    send_fields(16'd100,   16'd0,     16'd0,     16'd0);
    send_fields(16'd16384, 16'h8000,  16'd0,     16'd0);
    send_fields(16'd16384, 16'h7FFF,  16'd0,     16'd0);
    send_fields(16'd16384, 16'd0,     16'h8000,  16'd0);
    send_fields(16'd16384, 16'd0,     16'h7FFF,  16'd0);
    send_fields(16'd16384, 16'd0,     16'd0,     16'h8000);
    send_fields(16'd16384, 16'd0,     16'd0,     16'h7FFF);
    send_fields(16'd32768, 16'h7FFF,  16'h7FFF,  16'h7FFF);
    send_fields(16'd32768, 16'h8000,  16'h8000,  16'h8000);
    send_fields(16'd0,     16'h8000,  16'h8000,  16'h8000);
    send_fields(16'd1000,  16'd100,   16'hFF9C,  16'd50);
    send_fields(16'd65535, 16'h8000,  16'h7FFF,  16'h8000);
    send_fields(16'd30000, 16'hFFFF,  16'd1,     16'hFFFF);
    wait_drained();

    // random phases, each under its own gains and floor
    for (int k = 0; k < NUM_PHASES; k++) begin
      case (k)
        0:       begin ag = 16'd0;     yg = 16'd0;     fl = 16'd0;     end
        1:       begin ag = 16'hFFFF;  yg = 16'hFFFF;  fl = 16'd0;     end
        2:       begin ag = 16'hFFFF;  yg = 16'hFFFF;  fl = 16'd32768; end
        3:       begin ag = ATTITUDE_GAIN_RST; yg = YAW_GAIN_RST; fl = IDLE_FLOOR_RST; end
        4:       begin ag = 16'd0;     yg = 16'hFFFF;  fl = 16'hFFFF;  end
        7:       begin ag = 16'($urandom()); yg = 16'($urandom()); fl = 16'($urandom()); end
        default: begin
          ag = 16'($urandom());
          yg = 16'($urandom());
          fl = 16'($urandom_range(32768));
        end
      endcase
      // one phase runs with no idling on either side
      idle_on  = (k != 3);
      stall_on = (k != 3);
      write_reg(CFG_ATTITUDE_GAIN, ag);
      write_reg(CFG_YAW_GAIN, yg);
      write_reg(CFG_IDLE_FLOOR, fl);
      write_reg(CFG_UNUSED, 16'($urandom()));
      pause_at = $urandom_range(10, 90);
      for (int n = 0; n < PHASE_CMDS; n++) begin
        send_command(random_command());
        if (n == pause_at) wait_drained();
      end
      wait_drained();
    end

    // let any stray result show up
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("covered %0d commands under %0d register writes and %0d gain/floor settings",
             cmds_sent, reg_writes, NUM_PHASES + 1);
    $display("checked %0d drive sets, %0d of them rescaled", result_count, rescale_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/qxmm_pkg.sv
rtl/core/qxmm_mix.sv
rtl/core/qxmm_div.sv
rtl/core/quad_x_motor_mixer.sv
rtl/core/qxmm_chk.sv
tb/qxmm_checker.sv
tb/testbench.sv
